// ===== rtl/hpv_pkg.sv =====
`timescale 1ns / 1ps

package hpv_pkg;

  // default string length limit and depth of the queue between front and back
  localparam int MAX_TARGET_BYTES_DEF = 256;
  localparam int QUEUE_DEPTH          = 4;
  localparam int QUEUE_AW             = $clog2(QUEUE_DEPTH);

  // result status codes
  localparam logic [3:0] ST_OK        = 4'd0;
  localparam logic [3:0] ST_EMPTY     = 4'd1;
  localparam logic [3:0] ST_TOO_LONG  = 4'd2;
  localparam logic [3:0] ST_NONPRINT  = 4'd3;
  localparam logic [3:0] ST_BRACKET   = 4'd4;
  localparam logic [3:0] ST_NOT_HP    = 4'd5;
  localparam logic [3:0] ST_IPV6_BARE = 4'd6;
  localparam logic [3:0] ST_HOST_CHAR = 4'd7;
  localparam logic [3:0] ST_PORT      = 4'd8;

  // one classified word as it travels from front to back
  typedef struct packed {
    logic       has;
    logic       last;
    logic       is_print;
    logic       is_digit;
    logic       is_colon;
    logic       is_lbr;
    logic       is_rbr;
    logic       plain_ok;
    logic       br_ok;
    logic [3:0] digit;
  } item_t;

endpackage

// ===== rtl/hpv_front.sv =====
`timescale 1ns / 1ps

module hpv_front import hpv_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,
  input  logic       in_tuser,
  input  logic       in_tlast,
  output logic       fr_valid,
  input  logic       fr_ready,
  output item_t      fr_item
);

  logic  valid_r;
  item_t item_r;
  item_t item_nxt;
  logic  dig, upper, lower, hex_al;

  // character classes of the incoming byte
  always_comb begin
    dig    = (in_tdata >= 8'h30) && (in_tdata <= 8'h39);
    upper  = (in_tdata >= 8'h41) && (in_tdata <= 8'h5a);
    lower  = (in_tdata >= 8'h61) && (in_tdata <= 8'h7a);
    hex_al = ((in_tdata >= 8'h41) && (in_tdata <= 8'h46)) ||
             ((in_tdata >= 8'h61) && (in_tdata <= 8'h66));
    item_nxt.has      = in_tuser;
    item_nxt.last     = in_tlast;
    item_nxt.is_print = (in_tdata >= 8'h21) && (in_tdata <= 8'h7e);
    item_nxt.is_digit = dig;
    item_nxt.is_colon = (in_tdata == 8'h3a);
    item_nxt.is_lbr   = (in_tdata == 8'h5b);
    item_nxt.is_rbr   = (in_tdata == 8'h5d);
    item_nxt.plain_ok = dig || upper || lower || (in_tdata == 8'h2e) ||
                        (in_tdata == 8'h2d) || (in_tdata == 8'h5f);
    item_nxt.br_ok    = dig || hex_al || (in_tdata == 8'h3a) || (in_tdata == 8'h2e) ||
                        (in_tdata == 8'h25) || (in_tdata == 8'h2d) || (in_tdata == 8'h5f);
    item_nxt.digit    = in_tdata[3:0];
  end

  // single holding stage, refilled in the cycle it drains
  assign in_tready = !valid_r || fr_ready;
  assign fr_valid  = valid_r;
  assign fr_item   = item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_tready) begin
      valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      item_r <= item_nxt;
    end
  end

endmodule

// ===== rtl/hpv_queue.sv =====
`timescale 1ns / 1ps

module hpv_queue import hpv_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  push_valid,
  output logic  push_ready,
  input  item_t push_item,
  output logic  pop_valid,
  input  logic  pop,
  output item_t pop_item
);

  item_t                mem [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0]  wptr_r, rptr_r;
  logic [QUEUE_AW:0]    cnt_r;
  logic                 do_push, do_pop;

  assign push_ready = (cnt_r != (QUEUE_AW+1)'(QUEUE_DEPTH));
  assign pop_valid  = (cnt_r != '0);
  assign pop_item   = mem[rptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop && pop_valid;

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      if (do_push) wptr_r <= wptr_r + 1'b1;
      if (do_pop)  rptr_r <= rptr_r + 1'b1;
      if (do_push && !do_pop) cnt_r <= cnt_r + 1'b1;
      else if (do_pop && !do_push) cnt_r <= cnt_r - 1'b1;
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wptr_r] <= push_item;
    end
  end

endmodule

// ===== rtl/hpv_back.sv =====
`timescale 1ns / 1ps

module hpv_back import hpv_pkg::*; #(
  parameter int MAX_TARGET_BYTES = MAX_TARGET_BYTES_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       q_valid,
  output logic       q_pop,
  input  item_t      q_item,
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,
  output logic       out_tuser
);

  localparam int CW = $clog2(MAX_TARGET_BYTES + 2);
  localparam logic [CW-1:0] MAX_CNT = CW'(MAX_TARGET_BYTES);

  // parse phases
  localparam logic [2:0] PH_START    = 3'd0;
  localparam logic [2:0] PH_UNBR     = 3'd1;
  localparam logic [2:0] PH_BR_HOST  = 3'd2;
  localparam logic [2:0] PH_BR_AFTER = 3'd3;
  localparam logic [2:0] PH_BR_PORT  = 3'd4;

  logic [CW-1:0] bc_r, bc_nxt;
  logic [2:0]    phase_r, phase_nxt;
  logic          brk_r, brk_nxt;
  logic          np_r, np_nxt;
  logic          ferr_r, ferr_nxt;
  logic [1:0]    cc_r, cc_nxt;
  logic          cstart_r, cstart_nxt;
  logic          prevc_r, prevc_nxt;
  logic          hnz_r, hnz_nxt;
  logic          herr_r, herr_nxt;
  logic [2:0]    pdc_r, pdc_nxt;
  logic [16:0]   acc_r, acc_nxt;
  logic          perr_r, perr_nxt;
  logic          do_plain, do_port;
  logic [19:0]   prod;
  logic [3:0]    status_nxt;
  logic          out_valid_r;
  logic [3:0]    status_r;

  // take the next word whenever the output register is free or draining
  assign q_pop = q_valid && (!out_valid_r || out_tready);

  // per-byte state update
  always_comb begin
    bc_nxt     = bc_r;
    phase_nxt  = phase_r;
    brk_nxt    = brk_r;
    np_nxt     = np_r;
    ferr_nxt   = ferr_r;
    cc_nxt     = cc_r;
    cstart_nxt = cstart_r;
    prevc_nxt  = prevc_r;
    hnz_nxt    = hnz_r;
    herr_nxt   = herr_r;
    pdc_nxt    = pdc_r;
    acc_nxt    = acc_r;
    perr_nxt   = perr_r;
    do_plain   = 1'b0;
    do_port    = 1'b0;
    prod       = ({3'b000, acc_r} << 3) + ({3'b000, acc_r} << 1) + {16'd0, q_item.digit};
    if (q_item.has) begin
      if (bc_r <= MAX_CNT) bc_nxt = bc_r + 1'b1;
      if (!q_item.is_print) np_nxt = 1'b1;
      unique case (phase_r)
        PH_START: begin
          if (q_item.is_lbr) begin
            brk_nxt   = 1'b1;
            phase_nxt = PH_BR_HOST;
          end else begin
            phase_nxt = PH_UNBR;
            do_plain  = 1'b1;
          end
        end
        PH_UNBR: begin
          do_plain = 1'b1;
        end
        PH_BR_HOST: begin
          if (q_item.is_rbr) begin
            if (!hnz_r) ferr_nxt = 1'b1;
            phase_nxt = PH_BR_AFTER;
          end else begin
            hnz_nxt = 1'b1;
            if (!q_item.br_ok) herr_nxt = 1'b1;
          end
        end
        PH_BR_AFTER: begin
          if (!q_item.is_colon) ferr_nxt = 1'b1;
          phase_nxt = PH_BR_PORT;
        end
        default: begin
          do_port = 1'b1;
        end
      endcase
      // unbracketed host or port byte
      if (do_plain) begin
        if (q_item.is_colon) begin
          if ((cc_r == 2'd0) && (bc_nxt == CW'(1))) cstart_nxt = 1'b1;
          if (cc_r != 2'd3) cc_nxt = cc_r + 1'b1;
          prevc_nxt = 1'b1;
        end else begin
          prevc_nxt = 1'b0;
          if (cc_r == 2'd0) begin
            hnz_nxt = 1'b1;
            if (!q_item.plain_ok) herr_nxt = 1'b1;
          end else begin
            do_port = 1'b1;
          end
        end
      end
      // port digit accumulation
      if (do_port) begin
        if (pdc_r != 3'd6) pdc_nxt = pdc_r + 1'b1;
        if (!q_item.is_digit) begin
          perr_nxt = 1'b1;
        end else if (!perr_r && (pdc_nxt <= 3'd5)) begin
          acc_nxt = prod[16:0];
          if (prod > 20'd65535) perr_nxt = 1'b1;
        end
      end
    end
  end

  // verdict in check order
  always_comb begin
    if (bc_nxt == '0) begin
      status_nxt = ST_EMPTY;
    end else if (bc_nxt > MAX_CNT) begin
      status_nxt = ST_TOO_LONG;
    end else if (np_nxt) begin
      status_nxt = ST_NONPRINT;
    end else if (brk_nxt && (ferr_nxt || (phase_nxt != PH_BR_PORT))) begin
      status_nxt = ST_BRACKET;
    end else if (!brk_nxt && ((cc_nxt == 2'd0) || prevc_nxt ||
                              ((cc_nxt == 2'd1) && cstart_nxt))) begin
      status_nxt = ST_NOT_HP;
    end else if (!brk_nxt && (cc_nxt >= 2'd2)) begin
      status_nxt = ST_IPV6_BARE;
    end else if (herr_nxt) begin
      status_nxt = ST_HOST_CHAR;
    end else if (perr_nxt || (pdc_nxt == 3'd0) || (pdc_nxt > 3'd5) || (acc_nxt == '0)) begin
      status_nxt = ST_PORT;
    end else begin
      status_nxt = ST_OK;
    end
  end

  // parse state, cleared after every result
  always_ff @(posedge clk) begin
    if (!rst_n || (q_pop && q_item.last)) begin
      bc_r     <= '0;
      phase_r  <= PH_START;
      brk_r    <= 1'b0;
      np_r     <= 1'b0;
      ferr_r   <= 1'b0;
      cc_r     <= 2'd0;
      cstart_r <= 1'b0;
      prevc_r  <= 1'b0;
      hnz_r    <= 1'b0;
      herr_r   <= 1'b0;
      pdc_r    <= 3'd0;
      acc_r    <= '0;
      perr_r   <= 1'b0;
    end else if (q_pop) begin
      bc_r     <= bc_nxt;
      phase_r  <= phase_nxt;
      brk_r    <= brk_nxt;
      np_r     <= np_nxt;
      ferr_r   <= ferr_nxt;
      cc_r     <= cc_nxt;
      cstart_r <= cstart_nxt;
      prevc_r  <= prevc_nxt;
      hnz_r    <= hnz_nxt;
      herr_r   <= herr_nxt;
      pdc_r    <= pdc_nxt;
      acc_r    <= acc_nxt;
      perr_r   <= perr_nxt;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (q_pop && q_item.last) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop && q_item.last) begin
      status_r <= status_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'b0000, status_r};
  assign out_tuser  = (status_r == ST_OK);

endmodule

// ===== rtl/host_port_target_validator_unit.sv =====
`timescale 1ns / 1ps
// channel | direction | tdata                  | tuser        | tlast
// in_     | in        | [7:0] ch               | has_byte     | last_byte
// out_    | out       | [3:0] status, [7:4] 0  | is_valid     | -
//
// one word per cycle sustained unless output stalls fill the queue; a status is
// offered once the last word has passed the holding stage, queue and output
// register; rst_n is synchronous and active low; it empties the queue and clears
// the parse state; the holding stage and 4-entry queue absorb output stalls, and
// in_tready falls only once the queue is full

module host_port_target_validator_unit import hpv_pkg::*; #(
  parameter int MAX_TARGET_BYTES = MAX_TARGET_BYTES_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] ch
  input  logic       in_tuser,   // [0] has_byte
  input  logic       in_tlast,
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [3:0] status, [7:4] zero
  output logic       out_tuser   // [0] is_valid
);

  logic  fr_valid, fr_ready, q_valid, q_pop;
  item_t fr_item, q_item;

  // front: accept and classify
  hpv_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .in_tlast  (in_tlast),
    .fr_valid  (fr_valid),
    .fr_ready  (fr_ready),
    .fr_item   (fr_item)
  );

  // decoupling queue
  hpv_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (fr_valid),
    .push_ready (fr_ready),
    .push_item  (fr_item),
    .pop_valid  (q_valid),
    .pop        (q_pop),
    .pop_item   (q_item)
  );

  // back: parse state and verdict
  hpv_back #(
    .MAX_TARGET_BYTES (MAX_TARGET_BYTES)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_valid),
    .q_pop      (q_pop),
    .q_item     (q_item),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule

// ===== rtl/hpv_checker.sv =====
`timescale 1ns / 1ps

module hpv_checker import hpv_pkg::*; (
  input logic       clk,
  input logic       rst_n,
  input logic       in_tvalid,
  input logic       in_tready,
  input logic [7:0] in_tdata,
  input logic       in_tuser,
  input logic       in_tlast,
  input logic       out_tvalid,
  input logic       out_tready,
  input logic [7:0] out_tdata,
  input logic       out_tuser
);

  // an offered input word holds until taken
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && !in_tready |=> in_tvalid && $stable(in_tdata) && $stable(in_tuser) &&
                                $stable(in_tlast))
    else $error("input word changed while waiting");

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result word changed under stall");

  // is_valid agrees with the status
  a_valid_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tuser == (out_tdata[3:0] == ST_OK)))
    else $error("is_valid does not match status");

  // status stays within the defined codes, upper bits zero
  a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[3:0] <= ST_PORT) && (out_tdata[7:4] == 4'd0))
    else $error("status code out of range");

  // nothing is offered in the cycle after reset
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result offered straight after reset");

endmodule

bind host_port_target_validator_unit hpv_checker u_hpv_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tdata   (in_tdata),
  .in_tuser   (in_tuser),
  .in_tlast   (in_tlast),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
  import hpv_pkg::*;

  localparam int MAX_BYTES    = MAX_TARGET_BYTES_DEF;
  localparam int RANDOM_WORDS = 1000;
  localparam int HOLD_AT      = 1400;
  localparam int HOLD_CYCLES  = 400;
  localparam int CYCLE_LIMIT  = 1000000;

  typedef logic [7:0] text_t[$];

  typedef enum logic [2:0] {
    SCAN_START,
    SCAN_PLAIN,
    SCAN_BR_HOST,
    SCAN_BR_CLOSED,
    SCAN_BR_PORT
  } scan_phase_t;

  // target string checker: tracks the parse of the current string and holds
  // the status codes still owed by the block
  class target_scoreboard;
    int unsigned words_taken = 0;
    int unsigned mismatches = 0;
    logic [3:0] owed_status[$];

    int unsigned n_bytes;
    scan_phase_t phase;
    bit bracketed, nonprint, form_bad, colon_first, colon_last;
    bit host_seen, host_bad, port_bad;
    int unsigned colons, port_digits, port_value;

    function void clear();
      n_bytes = 0;
      phase = SCAN_START;
      bracketed = 0;
      nonprint = 0;
      form_bad = 0;
      colon_first = 0;
      colon_last = 0;
      host_seen = 0;
      host_bad = 0;
      port_bad = 0;
      colons = 0;
      port_digits = 0;
      port_value = 0;
    endfunction

    function bit is_dec(logic [7:0] b);
      return b >= "0" && b <= "9";
    endfunction

    function bit is_hexd(logic [7:0] b);
      return is_dec(b) || (b >= "A" && b <= "F") || (b >= "a" && b <= "f");
    endfunction

    function bit plain_ok(logic [7:0] b);
      return is_dec(b) || (b >= "A" && b <= "Z") || (b >= "a" && b <= "z") ||
             b == "." || b == "-" || b == "_";
    endfunction

    function bit bracket_ok(logic [7:0] b);
      return is_hexd(b) || b == ":" || b == "." || b == "%" || b == "-" || b == "_";
    endfunction

    function void port_char(logic [7:0] b);
      if (port_digits < 6) port_digits++;
      if (!is_dec(b)) begin
        port_bad = 1;
        return;
      end
      if (!port_bad && port_digits <= 5) begin
        port_value = port_value * 10 + (b - "0");
        if (port_value > 65535) port_bad = 1;
      end
    endfunction

    function void plain_char(logic [7:0] b);
      if (b == ":") begin
        if (colons == 0 && n_bytes == 1) colon_first = 1;
        if (colons < 3) colons++;
        colon_last = 1;
      end else begin
        colon_last = 0;
        if (colons == 0) begin
          host_seen = 1;
          if (!plain_ok(b)) host_bad = 1;
        end else begin
          port_char(b);
        end
      end
    endfunction

    function void take_char(logic [7:0] b);
      if (n_bytes <= MAX_BYTES) n_bytes++;
      if (b < 8'h21 || b > 8'h7e) nonprint = 1;
      case (phase)
        SCAN_START: begin
          if (b == "[") begin
            bracketed = 1;
            phase = SCAN_BR_HOST;
          end else begin
            phase = SCAN_PLAIN;
            plain_char(b);
          end
        end
        SCAN_PLAIN: plain_char(b);
        SCAN_BR_HOST: begin
          if (b == "]") begin
            if (!host_seen) form_bad = 1;
            phase = SCAN_BR_CLOSED;
          end else begin
            host_seen = 1;
            if (!bracket_ok(b)) host_bad = 1;
          end
        end
        SCAN_BR_CLOSED: begin
          if (b != ":") form_bad = 1;
          phase = SCAN_BR_PORT;
        end
        default: port_char(b);
      endcase
    endfunction

    // first failing check in priority order gives the status
    function logic [3:0] status_now();
      if (n_bytes == 0) return ST_EMPTY;
      if (n_bytes > MAX_BYTES) return ST_TOO_LONG;
      if (nonprint) return ST_NONPRINT;
      if (bracketed) begin
        if (form_bad || phase != SCAN_BR_PORT) return ST_BRACKET;
      end else begin
        if (colons == 0 || colon_last || (colons == 1 && colon_first)) return ST_NOT_HP;
        if (colons >= 2) return ST_IPV6_BARE;
      end
      if (host_bad) return ST_HOST_CHAR;
      if (port_bad || port_digits == 0 || port_digits > 5 || port_value == 0)
        return ST_PORT;
      return ST_OK;
    endfunction

    function void note_word(logic [7:0] ch, logic has, logic last);
      words_taken++;
      if (has) take_char(ch);
      if (last) begin
        owed_status.insert(owed_status.size(), status_now());
        clear();
      end
    endfunction

    function void check_result(logic [7:0] tdata, logic tuser);
      logic [3:0] want;
      if (owed_status.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected status word: tdata %h tuser %b", tdata, tuser);
        return;
      end
      want = owed_status.pop_front();
      if (tdata[3:0] != want || tdata[7:4] != 4'd0 || tuser != (want == ST_OK)) begin
        mismatches++;
        if (mismatches <= 10)
          $display("status mismatch: expected status %0d valid %b, got tdata %h tuser %b",
                   want, want == ST_OK, tdata, tuser);
      end
    endfunction

    function int pending();
      return owed_status.size();
    endfunction
  endclass

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_tvalid = 1'b0;
  logic       in_tready;
  logic [7:0] in_tdata = 8'd0;
  logic       in_tuser = 1'b0;
  logic       in_tlast = 1'b0;
  logic       out_tvalid;
  logic       out_tready = 1'b0;
  logic [7:0] out_tdata;
  logic       out_tuser;

  target_scoreboard sb;
  int unsigned cycle_count = 0;
  int unsigned words_offered = 0;
  int tx_quiet = 0;
  int rx_quiet = 0;
  bit held_off = 1'b0;

  host_port_target_validator_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAIL host_port_target_validator_unit");
      $finish;
    end
  end

  // mostly short gaps, a few long ones, and now and then a quiet run with none
  function automatic int pick_gap(inout int quiet);
    int r;
    if (quiet > 0) begin
      quiet--;
      return 0;
    end
    r = $urandom_range(0, 999);
    if (r < 5) begin
      quiet = $urandom_range(20, 80);
      return 0;
    end
    if (r < 600) return 0;
    if (r < 950) return $urandom_range(1, 3);
    return $urandom_range(4, 40);
  endfunction

  function automatic text_t to_text(string s);
    text_t t;
    for (int i = 0; i < s.len(); i++) t.insert(t.size(), s[i]);
    return t;
  endfunction

  // random target: mostly well-formed with random content, some broken, some noise
  function automatic text_t make_target();
    string plain_set = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ0123456789.-_";
    string br_set = "0123456789abcdefABCDEF:.%-_";
    string edge_ports[4] = '{"65535", "65536", "00000", "99999"};
    text_t t;
    int kind;
    int r;
    int pos;
    kind = $urandom_range(0, 199);
    if (kind >= 170) begin
      repeat ($urandom_range(0, 10)) t.insert(t.size(), 8'($urandom));
    end else if (kind == 169) begin
      repeat ($urandom_range(MAX_BYTES - 8, MAX_BYTES + 4)) t.insert(t.size(), "a");
      t.insert(t.size(), ":");
      t.insert(t.size(), "9");
    end else begin
      if (kind % 2 == 0) begin
        repeat ($urandom_range(0, 8))
          t.insert(t.size(), $urandom_range(0, 19) == 0 ? 8'($urandom_range(8'h21, 8'h7e)) :
                   plain_set[$urandom_range(0, plain_set.len() - 1)]);
      end else begin
        t.insert(t.size(), "[");
        repeat ($urandom_range(0, 10))
          t.insert(t.size(), $urandom_range(0, 19) == 0 ? 8'($urandom_range(8'h21, 8'h7e)) :
                   br_set[$urandom_range(0, br_set.len() - 1)]);
        t.insert(t.size(), "]");
      end
      t.insert(t.size(), ":");
      r = $urandom_range(0, 19);
      if (r == 0) begin
        // no port digits
      end else if (r == 1) begin
        repeat ($urandom_range(6, 7)) t.insert(t.size(), 8'("0" + $urandom_range(0, 9)));
      end else if (r == 2) begin
        t = {t, to_text(edge_ports[$urandom_range(0, 3)])};
      end else begin
        repeat ($urandom_range(1, 5)) t.insert(t.size(), 8'("0" + $urandom_range(0, 9)));
      end
      // break the form of roughly a third of them
      if (kind >= 110) begin
        pos = $urandom_range(0, t.size() - 1);
        case ($urandom_range(0, 3))
          0: t[pos] = 8'($urandom);
          1: t.insert(pos, ":");
          2: t.insert(pos, $urandom_range(0, 1) ? "[" : "]");
          default: t.delete(pos);
        endcase
      end
    end
    return t;
  endfunction

  // offer one word after a random gap and wait for it to be taken
  task automatic send_word(input logic [7:0] ch, input logic has, input logic last);
    int gap;
    gap = pick_gap(tx_quiet);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= ch;
    in_tuser <= has;
    in_tlast <= last;
    if (has || last) words_offered++;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.note_word(ch, has, last);
  endtask

  // one target string, with stray idle words; end_apart closes it with a
  // word that carries no byte
  task automatic send_text(input text_t t, input bit end_apart);
    int n;
    n = t.size();
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 19) == 0) send_word(8'($urandom), 1'b0, 1'b0);
      send_word(t[i], 1'b1, !end_apart && i == n - 1);
    end
    if (end_apart || n == 0) send_word(8'($urandom), 1'b0, 1'b1);
  endtask

  // sender pause until every owed status has come back
  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  // result checking
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tdata, out_tuser);
  end

  // receiver: random stalls plus one long hold-off to fill the block up
  initial begin
    int stall;
    wait (rst_n);
    @(posedge clk);
    forever begin
      if (!held_off && sb.words_taken >= HOLD_AT) begin
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        held_off = 1'b1;
      end else begin
        stall = pick_gap(rx_quiet);
        if (stall > 0) begin
          out_tready <= 1'b0;
          repeat (stall) @(posedge clk);
        end
      end
      out_tready <= 1'b1;
      @(posedge clk);
    end
  end

  // stimulus
  initial begin
    string directed_targets[] = '{
      "a:1", "host.Example-1_z:65535", "a:65536", "a:0", "a:00080", "a:000080",
      ":80", "a:", "abc", "a:b:c", "h$t:1", "a:1x", "[::1]:443", "[fe80::1%25]:1",
      "[]:80", "[::1]x80", "[::1]", "[g]:1", "[::1]:"
    };
    text_t t;
    int len;
    int base;
    bit mid_drained;
    sb = new;
    sb.clear();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // directed: empty string, form and port cases, edges of the printable range
    send_text(t, 1'b0);
    foreach (directed_targets[i]) send_text(to_text(directed_targets[i]), 1'b0);
    send_text(to_text("[::1]:8080"), 1'b1);
    send_text('{8'h61, 8'h20, 8'h3a, 8'h31}, 1'b0);
    send_text('{8'h61, 8'h3a, 8'h31, 8'h7f}, 1'b0);
    send_text('{8'h00}, 1'b0);
    send_text('{8'hff, 8'h80}, 1'b0);
    send_text('{8'h21, 8'h7e, 8'h3a, 8'h31}, 1'b0);

    // length limit: exactly at it, one over, and well past it
    for (int k = 0; k < 3; k++) begin
      len = (k == 0) ? MAX_BYTES : (k == 1) ? MAX_BYTES + 1 : MAX_BYTES + 44;
      t.delete();
      repeat (len - 2) t.insert(t.size(), "a");
      t.insert(t.size(), ":");
      t.insert(t.size(), "1");
      if (k == 2) t[5] = 8'h00;
      send_text(t, 1'b0);
    end
    drain();

    // random targets
    base = words_offered;
    mid_drained = 1'b0;
    while (words_offered - base < RANDOM_WORDS) begin
      send_text(make_target(), $urandom_range(0, 9) == 0);
      if (!mid_drained && words_offered - base >= RANDOM_WORDS / 2) begin
        drain();
        mid_drained = 1'b1;
      end
    end

    // wind down
    in_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (sb.mismatches == 0)
      $display("PASS host_port_target_validator_unit");
    else
      $display("FAIL host_port_target_validator_unit");
    $finish;
  end

endmodule
